// File: sv/i2cm_pkg.sv
// shared constants and types for the i2c master byte engine
package i2cm_pkg;

    localparam int DIVIDER_WIDTH_DEF = 16;
    localparam int CFG_WIDTH         = 16;
    localparam logic [CFG_WIDTH-1:0] HALF_PERIOD_RESET = 16'd5;

    localparam int OP_WIDTH   = 3;
    localparam int BYTE_WIDTH = 8;
    localparam int CNT_WIDTH  = 4;
    localparam logic [CNT_WIDTH-1:0] BITS_PER_BYTE = 4'd8;

    localparam int IN_TDATA_WIDTH  = 16;
    localparam int OUT_TDATA_WIDTH = 16;

    localparam logic [OP_WIDTH-1:0] OP_NONE  = 3'd0;
    localparam logic [OP_WIDTH-1:0] OP_START = 3'd1;
    localparam logic [OP_WIDTH-1:0] OP_STOP  = 3'd2;
    localparam logic [OP_WIDTH-1:0] OP_WRITE = 3'd3;
    localparam logic [OP_WIDTH-1:0] OP_READ  = 3'd4;

    typedef struct packed {
        logic [BYTE_WIDTH-1:0] rx_byte;
        logic                  nack_error;
        logic                  done_res;
        logic                  busy_res;
        logic                  sda_low;
        logic                  scl_low;
    } t_result;

endpackage

// File: sv/i2cm_core.sv
// bus sequencer state and per-cycle next-state logic
module i2cm_core import i2cm_pkg::*; #(
    parameter int DIVIDER_WIDTH = DIVIDER_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [CFG_WIDTH-1:0]  i_half_period,
    input  logic [OP_WIDTH-1:0]   i_op,
    input  logic [BYTE_WIDTH-1:0] i_tx_byte,
    input  logic                  i_nack_reply,
    input  logic                  i_sda_in,
    output t_result               o_result
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST_FREE,
        PH_ST_SDA,
        PH_ST_SCL,
        PH_SP_LOW,
        PH_SP_SCL,
        PH_SP_SDA,
        PH_WB_LOW,
        PH_WB_HIGH,
        PH_WA_LOW,
        PH_WA_HIGH,
        PH_RB_LOW,
        PH_RB_HIGH,
        PH_RA_LOW,
        PH_RA_HIGH
    } t_phase;

    localparam logic [DIVIDER_WIDTH-1:0] DIV_ONE = DIVIDER_WIDTH'(1);

    t_phase                   r_phase, n_phase, enter_phase;
    logic [CNT_WIDTH-1:0]     r_bit_cnt, n_bit_cnt;
    logic [BYTE_WIDTH-1:0]    r_shift, n_shift;
    logic [DIVIDER_WIDTH-1:0] r_div_cnt, n_div_cnt;
    logic [OP_WIDTH-1:0]      r_active_op, n_active_op;
    logic                     r_nack_pend, n_nack_pend;
    logic                     r_scl, n_scl;
    logic                     r_sda, n_sda;
    logic [BYTE_WIDTH-1:0]    r_rx, n_rx;

    logic [DIVIDER_WIDTH-1:0] hp_raw, hp, cnt_inc;
    logic                     do_enter, done, err;

    assign hp_raw  = DIVIDER_WIDTH'(i_half_period);
    assign hp      = (hp_raw == '0) ? DIV_ONE : hp_raw;
    assign cnt_inc = r_div_cnt + DIV_ONE;

    always_comb begin
        n_phase     = r_phase;
        n_bit_cnt   = r_bit_cnt;
        n_shift     = r_shift;
        n_div_cnt   = r_div_cnt;
        n_active_op = r_active_op;
        n_nack_pend = r_nack_pend;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_rx        = r_rx;
        enter_phase = r_phase;
        do_enter    = 1'b0;
        done        = 1'b0;
        err         = 1'b0;

        if (i_step) begin
            if (r_phase == PH_IDLE) begin
                if (i_op == OP_START || i_op == OP_STOP ||
                    i_op == OP_WRITE || i_op == OP_READ) begin
                    n_active_op = i_op;
                    n_bit_cnt   = '0;
                    do_enter    = 1'b1;
                    case (i_op)
                        OP_START: enter_phase = PH_ST_FREE;
                        OP_STOP:  enter_phase = PH_SP_LOW;
                        OP_WRITE: begin
                            n_shift     = i_tx_byte;
                            n_nack_pend = 1'b0;
                            enter_phase = PH_WB_LOW;
                        end
                        default: begin
                            n_shift     = '0;
                            n_nack_pend = i_nack_reply;
                            enter_phase = PH_RB_LOW;
                        end
                    endcase
                end
            end else if (cnt_inc >= hp || cnt_inc == '0) begin
                n_div_cnt = '0;
                case (r_phase)
                    PH_ST_FREE: begin do_enter = 1'b1; enter_phase = PH_ST_SDA; end
                    PH_ST_SDA:  begin do_enter = 1'b1; enter_phase = PH_ST_SCL; end
                    PH_SP_LOW:  begin do_enter = 1'b1; enter_phase = PH_SP_SCL; end
                    PH_SP_SCL:  begin do_enter = 1'b1; enter_phase = PH_SP_SDA; end
                    PH_WB_LOW:  begin do_enter = 1'b1; enter_phase = PH_WB_HIGH; end
                    PH_WA_LOW:  begin do_enter = 1'b1; enter_phase = PH_WA_HIGH; end
                    PH_RB_LOW:  begin do_enter = 1'b1; enter_phase = PH_RB_HIGH; end
                    PH_RA_LOW:  begin do_enter = 1'b1; enter_phase = PH_RA_HIGH; end
                    PH_WB_HIGH: begin
                        n_shift     = {r_shift[BYTE_WIDTH-2:0], 1'b0};
                        n_bit_cnt   = r_bit_cnt + 4'd1;
                        do_enter    = 1'b1;
                        enter_phase = (n_bit_cnt >= BITS_PER_BYTE) ? PH_WA_LOW : PH_WB_LOW;
                    end
                    PH_RB_HIGH: begin
                        n_shift     = {r_shift[BYTE_WIDTH-2:0], i_sda_in};
                        n_bit_cnt   = r_bit_cnt + 4'd1;
                        do_enter    = 1'b1;
                        enter_phase = (n_bit_cnt >= BITS_PER_BYTE) ? PH_RA_LOW : PH_RB_LOW;
                    end
                    PH_WA_HIGH: begin
                        n_nack_pend = i_sda_in;
                        n_scl       = 1'b1;
                        done        = 1'b1;
                    end
                    PH_RA_HIGH: begin
                        n_rx  = r_shift;
                        n_scl = 1'b1;
                        done  = 1'b1;
                    end
                    default: done = 1'b1;
                endcase
                if (done) begin
                    n_phase = PH_IDLE;
                    err     = (r_active_op == OP_WRITE) && n_nack_pend;
                end
            end else begin
                n_div_cnt = cnt_inc;
            end
        end

        if (do_enter) begin
            n_phase   = enter_phase;
            n_div_cnt = '0;
            case (enter_phase)
                PH_ST_FREE: begin n_scl = 1'b0; n_sda = 1'b0; end
                PH_ST_SDA:  begin n_scl = 1'b0; n_sda = 1'b1; end
                PH_ST_SCL:  begin n_scl = 1'b1; n_sda = 1'b1; end
                PH_SP_LOW:  begin n_scl = 1'b1; n_sda = 1'b1; end
                PH_SP_SCL:  begin n_scl = 1'b0; n_sda = 1'b1; end
                PH_SP_SDA:  begin n_scl = 1'b0; n_sda = 1'b0; end
                PH_WB_LOW:  begin n_scl = 1'b1; n_sda = ~n_shift[BYTE_WIDTH-1]; end
                PH_WA_LOW:  begin n_scl = 1'b1; n_sda = 1'b0; end
                PH_RB_LOW:  begin n_scl = 1'b1; n_sda = 1'b0; end
                PH_RA_LOW:  begin n_scl = 1'b1; n_sda = ~n_nack_pend; end
                default:    n_scl = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_cnt   <= '0;
            r_shift     <= '0;
            r_div_cnt   <= '0;
            r_active_op <= OP_NONE;
            r_nack_pend <= 1'b0;
            r_scl       <= 1'b0;
            r_sda       <= 1'b0;
            r_rx        <= '0;
        end else begin
            r_phase     <= n_phase;
            r_bit_cnt   <= n_bit_cnt;
            r_shift     <= n_shift;
            r_div_cnt   <= n_div_cnt;
            r_active_op <= n_active_op;
            r_nack_pend <= n_nack_pend;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_rx        <= n_rx;
        end
    end

    always_comb begin
        o_result.scl_low    = n_scl;
        o_result.sda_low    = n_sda;
        o_result.busy_res   = (n_phase != PH_IDLE);
        o_result.done_res   = done;
        o_result.nack_error = err;
        o_result.rx_byte    = n_rx;
    end

endmodule

// File: sv/i2cm_out_reg.sv
// result register with stream handshake toward the consumer
module i2cm_out_reg import i2cm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_m_tready,
    output logic    o_ready,
    output logic    o_m_tvalid,
    output t_result o_result
);

    logic    r_valid, n_valid;
    t_result r_result;

    assign o_ready = !r_valid || i_m_tready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_result   = r_result;

endmodule

// File: sv/i2c_master_byte_engine.sv
// i2c master byte engine top level: config register, sequencer, result register
// a result beat is registered and appears in the cycle after its input beat is accepted
// throughput: one beat per cycle unless the input side stalls, as the sequencer updates on every accepted beat
// the input side stalls only while a result beat waits and the consumer holds tready low
// reset: synchronous active low, bus released, sequencer idle, half period back to 5
module i2c_master_byte_engine import i2cm_pkg::*; #(
    parameter int DIVIDER_WIDTH = DIVIDER_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // op[2:0], tx_byte[10:3], nack_reply[11], sda_in[12], zero pad [15:13]
    input  logic [IN_TDATA_WIDTH-1:0]  i_s_tdata,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // scl_low[0], sda_low[1], busy_res[2], done_res[3], nack_error[4], rx_byte[12:5],
    // zero pad [15:13]
    output logic [OUT_TDATA_WIDTH-1:0] o_m_tdata,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_WIDTH-1:0]       i_cfg_data
);

    logic [CFG_WIDTH-1:0] r_half_period;
    logic                 step;
    t_result              core_res, out_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RESET;
        end else if (i_cfg_valid) begin
            r_half_period <= i_cfg_data;
        end
    end

    assign step = i_s_tvalid && o_s_tready;

    i2cm_core #(
        .DIVIDER_WIDTH(DIVIDER_WIDTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_half_period (r_half_period),
        .i_op          (i_s_tdata[2:0]),
        .i_tx_byte     (i_s_tdata[10:3]),
        .i_nack_reply  (i_s_tdata[11]),
        .i_sda_in      (i_s_tdata[12]),
        .o_result      (core_res)
    );

    i2cm_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step),
        .i_result   (core_res),
        .i_m_tready (i_m_tready),
        .o_ready    (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_result   (out_res)
    );

    assign o_m_tdata = {3'b000, out_res};

endmodule

// File: sv/i2cm_checker.sv
// port-level checks for the i2c master byte engine, bound to the top level
module i2cm_checker import i2cm_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_s_tvalid,
    input logic                       o_s_tready,
    input logic                       o_m_tvalid,
    input logic                       i_m_tready,
    input logic [OUT_TDATA_WIDTH-1:0] o_m_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat changed while stalled");

    // input side open whenever no result waits
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty result register");

    // every accepted beat yields a result beat next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> o_m_tvalid)
        else $error("accepted beat produced no result");

    // done only when the sequence has ended
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[3] |-> !o_m_tdata[2])
        else $error("done while busy");

    // nack error only with done
    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[4] |-> o_m_tdata[3])
        else $error("nack error without done");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (.*);
